// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication on the rising clock edge, muted while in reset.
`define AST_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the rising clock edge, muted while in reset.
`define AST_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_IMPL(lbl, ck, rn, ante, cons, msg)
`define AST_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// File: hdl/gbsrt_pkg.sv
package gbsrt_pkg;

    // Default configuration
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_DEPTH_DEF  = 64;
    localparam int ID_BITS_DEF     = 16;

    // Field widths on the ports
    localparam int REQ_W   = 3;
    localparam int CX_W    = 6;
    localparam int CY_W    = 6;
    localparam int EID_W   = 16;
    localparam int POS_W   = 10;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 11;
    localparam int RCELL_W = 12;
    localparam int CNT_W   = 11;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QCELL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_GRID  = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic append_wr;
        logic count_clr;
        logic rd_pos;
        logic rd_range;
        logic clr_start;
        logic clr_step;
        logic sort_init;
        logic rd_i;
        logic load_cur;
        logic rd_j;
        logic cmp_j;
        logic wr_i;
        logic fill_init;
        logic rd_fill;
        logic fill_step;
        logic fill_flush;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             grid_ok;
        logic             full;
        logic             pos_ok;
        logic             count_zero;
        logic             clr_last;
        logic             i_last;
        logic             j_done;
        logic             fill_done;
        logic             out_free;
    } sts_t;

endpackage

// File: hdl/grid_bin_sort_range_table.sv
// Channel  Dir  tdata                                        tuser
// s_*      in   cell_x, cell_y, entry_id, position           req_type
// m_*      out  first_index, last_index, read_id, read_cell,  status
//               entry_count
//
// Clear, append, cell query and position read each pass from the transfer
// through the execute and response states to the result; append, query and read
// make at most one access of the entry store or range table. For n entries, build
// runs an exchange sort that compares each held entry with every later one,
// writing the entry store on a swap; then the range table is swept to -1 one
// cell per cycle and refilled in one pass. Build with no entries does neither.
// After reset the range table is swept to -1 with s_tready low.
// A result waits in the output register while m_tready is low; the next
// transfer is accepted meanwhile, and that item's result waits behind it.
module grid_bin_sort_range_table
    import gbsrt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_DEPTH  = GRID_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cell_x, cell_y, entry_id, position, zero pad
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // first_index, last_index, read_id, read_cell,
                                   // entry_count, zero pad
    output logic [1:0]  m_tuser    // status
);

    cmd_t               cmd;
    sts_t               sts;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   last_index;
    logic [EID_W-1:0]   read_id;
    logic [RCELL_W-1:0] read_cell;
    logic [CNT_W-1:0]   entry_count;

    gbsrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbsrt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_DEPTH  (GRID_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (s_tuser),
        .cell_x      (s_tdata[5:0]),
        .cell_y      (s_tdata[11:6]),
        .entry_id    (s_tdata[27:12]),
        .position    (s_tdata[37:28]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .status      (m_tuser),
        .first_index (first_index),
        .last_index  (last_index),
        .read_id     (read_id),
        .read_cell   (read_cell),
        .entry_count (entry_count)
    );

    // Pack result fields
    assign m_tdata = {3'b000, entry_count, read_cell, read_id, last_index, first_index};

endmodule

// File: hdl/gbsrt_ram.sv
module gbsrt_ram
    import gbsrt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gbsrt_ctrl.sv
`include "assert_macros.svh"

module gbsrt_ctrl
    import gbsrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_RESP    = 4'd3;
    localparam logic [3:0] S_SI_RD   = 4'd4;
    localparam logic [3:0] S_SI_LD   = 4'd5;
    localparam logic [3:0] S_SJ_RD   = 4'd6;
    localparam logic [3:0] S_SJ_CMP  = 4'd7;
    localparam logic [3:0] S_BCLR    = 4'd8;
    localparam logic [3:0] S_FILL_RD = 4'd9;
    localparam logic [3:0] S_FILL_ST = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Sequence commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                unique case (sts.req)
                    REQ_CLEAR:  cmd.count_clr = 1'b1;
                    REQ_APPEND: cmd.append_wr = sts.grid_ok && !sts.full;
                    REQ_BUILD:
                    begin
                        if (!sts.count_zero)
                        begin
                            cmd.sort_init = 1'b1;
                            state_next    = S_SI_RD;
                        end
                    end
                    REQ_QCELL:  cmd.rd_range = sts.grid_ok;
                    REQ_READ:   cmd.rd_pos   = sts.pos_ok;
                    default:    cmd.latch    = 1'b0;
                endcase
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SI_RD:
            begin
                if (sts.i_last)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_BCLR;
                end
                else
                begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_SI_LD;
                end
            end
            S_SI_LD:
            begin
                cmd.load_cur = 1'b1;
                state_next   = S_SJ_RD;
            end
            S_SJ_RD:
            begin
                if (sts.j_done)
                begin
                    cmd.wr_i   = 1'b1;
                    state_next = S_SI_RD;
                end
                else
                begin
                    cmd.rd_j   = 1'b1;
                    state_next = S_SJ_CMP;
                end
            end
            S_SJ_CMP:
            begin
                cmd.cmp_j  = 1'b1;
                state_next = S_SJ_RD;
            end
            S_BCLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.fill_init = 1'b1;
                    state_next    = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                if (sts.fill_done)
                begin
                    cmd.fill_flush = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.rd_fill = 1'b1;
                    state_next  = S_FILL_ST;
                end
            end
            S_FILL_ST:
            begin
                cmd.fill_step = 1'b1;
                state_next    = S_FILL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `AST_NEXT(a_accept_exec, clk, rst_n, (state_reg == S_IDLE) && s_tvalid, state_reg == S_EXEC, "accepted transfer not executed")
    `AST_IMPL(a_clr_only_sweep, clk, rst_n, cmd.clr_step, (state_reg == S_INIT) || (state_reg == S_BCLR), "table clear outside sweep")
    `AST_IMPL(a_ready_free, clk, rst_n, s_tready, !cmd.out_load && !cmd.clr_step, "input taken during work")

endmodule

// File: hdl/gbsrt_dp.sv
`include "assert_macros.svh"

module gbsrt_dp
    import gbsrt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_DEPTH  = GRID_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [CX_W-1:0]    cell_x,
    input  logic [CY_W-1:0]    cell_y,
    input  logic [EID_W-1:0]   entry_id,
    input  logic [POS_W-1:0]   position,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   first_index,
    output logic [IDX_W-1:0]   last_index,
    output logic [EID_W-1:0]   read_id,
    output logic [RCELL_W-1:0] read_cell,
    output logic [CNT_W-1:0]   entry_count
);

    localparam int CELLS = GRID_WIDTH * GRID_DEPTH;
    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = AW + 1;
    localparam int EW    = KEY_W + ID_BITS;

    // Latched request
    logic [REQ_W-1:0]   req_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               grid_ok_reg;
    logic               full_reg;
    logic               pos_ok_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [EW-1:0]      cur_reg;
    logic [KEY_W-1:0]   clr_addr_reg;
    logic [KEY_W-1:0]   run_key_reg;
    logic [RW-1:0]      run_first_reg;
    logic               run_valid_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [EID_W-1:0]   rid_reg;
    logic [RCELL_W-1:0] rcell_reg;
    logic [CNT_W-1:0]   rcount_reg;

    // Entry store and range table ports
    logic               e_we;
    logic [AW-1:0]      e_waddr;
    logic [EW-1:0]      e_wdata;
    logic               e_re;
    logic [AW-1:0]      e_raddr;
    logic [EW-1:0]      e_rdata;
    logic               r_we;
    logic [KEY_W-1:0]   r_waddr;
    logic [2*RW-1:0]    r_wdata;
    logic [2*RW-1:0]    r_rdata;

    logic [KEY_W-1:0]   rd_key;
    logic               swap;
    logic               run_break;
    logic [RW-1:0]      run_last;
    logic               in_grid_ok;
    logic [KEY_W-1:0]   in_key;

    assign rd_key     = e_rdata[EW-1:ID_BITS];
    assign swap       = cur_reg[EW-1:ID_BITS] > rd_key;
    assign run_break  = !run_valid_reg || (rd_key != run_key_reg);
    assign run_last   = RW'(i_reg) - RW'(1);
    assign in_grid_ok = (int'(cell_x) < GRID_WIDTH) && (int'(cell_y) < GRID_DEPTH);
    assign in_key     = KEY_W'(int'(cell_x) + int'(cell_y) * GRID_WIDTH);

    // Steer entry store ports
    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = count_reg[AW-1:0];
        e_wdata = cur_reg;
        if (cmd.append_wr)
        begin
            e_we    = 1'b1;
            e_wdata = {key_reg, id_reg};
        end
        else if (cmd.cmp_j && swap)
        begin
            e_we    = 1'b1;
            e_waddr = j_reg[AW-1:0];
        end
        else if (cmd.wr_i)
        begin
            e_we    = 1'b1;
            e_waddr = i_reg[AW-1:0];
        end
        e_re    = cmd.rd_pos || cmd.rd_i || cmd.rd_j || cmd.rd_fill;
        e_raddr = cmd.rd_pos ? AW'(pos_reg) : (cmd.rd_j ? j_reg[AW-1:0] : i_reg[AW-1:0]);
    end

    // Steer range table write port
    always_comb
    begin
        r_we    = cmd.clr_step || cmd.fill_flush ||
                  (cmd.fill_step && run_valid_reg && (rd_key != run_key_reg));
        r_waddr = cmd.clr_step ? clr_addr_reg : run_key_reg;
        r_wdata = cmd.clr_step ? '1 : {run_first_reg, run_last};
    end

    gbsrt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    gbsrt_ram #(.WIDTH(2*RW), .DEPTH(CELLS)) u_range_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (cmd.rd_range),
        .raddr (key_reg),
        .rdata (r_rdata)
    );

    // Capture request payload, the held sort entry and the run start
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg     <= in_key;
            id_reg      <= ID_BITS'(entry_id);
            pos_reg     <= position;
            grid_ok_reg <= in_grid_ok;
            full_reg    <= int'(count_reg) >= MAX_ENTRIES;
            pos_ok_reg  <= (int'(position) < int'(count_reg)) &&
                           (int'(position) < MAX_ENTRIES);
        end
        if (cmd.load_cur || (cmd.cmp_j && swap))
        begin
            cur_reg <= e_rdata;
        end
        if (cmd.fill_step && run_break)
        begin
            run_key_reg   <= rd_key;
            run_first_reg <= RW'(i_reg);
        end
    end

    // Hold control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= REQ_CLEAR;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            clr_addr_reg  <= '0;
            run_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                req_reg <= req_type;
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.append_wr)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.sort_init || cmd.fill_init)
            begin
                i_reg <= '0;
            end
            else if (cmd.wr_i || cmd.fill_step)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.rd_i)
            begin
                j_reg <= i_reg + CW'(1);
            end
            else if (cmd.cmp_j)
            begin
                j_reg <= j_reg + CW'(1);
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + KEY_W'(1);
            end
            if (cmd.fill_init)
            begin
                run_valid_reg <= 1'b0;
            end
            else if (cmd.fill_step)
            begin
                run_valid_reg <= 1'b1;
            end
        end
    end

    // Hold result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Build result fields
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= ST_OK;
            first_reg  <= '1;
            last_reg   <= '1;
            rid_reg    <= '0;
            rcell_reg  <= '0;
            rcount_reg <= CNT_W'(count_reg);
            case (req_reg)
                REQ_APPEND:
                begin
                    if (!grid_ok_reg)
                    begin
                        status_reg <= ST_GRID;
                    end
                    else if (full_reg)
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                REQ_QCELL:
                begin
                    if (!grid_ok_reg)
                    begin
                        status_reg <= ST_GRID;
                    end
                    else
                    begin
                        first_reg <= IDX_W'(signed'(r_rdata[2*RW-1:RW]));
                        last_reg  <= IDX_W'(signed'(r_rdata[RW-1:0]));
                    end
                end
                REQ_READ:
                begin
                    if (!pos_ok_reg)
                    begin
                        status_reg <= ST_RANGE;
                    end
                    else
                    begin
                        rid_reg   <= EID_W'(e_rdata[ID_BITS-1:0]);
                        rcell_reg <= RCELL_W'(rd_key);
                    end
                end
                default:
                begin
                    status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign sts.req        = req_reg;
    assign sts.grid_ok    = grid_ok_reg;
    assign sts.full       = full_reg;
    assign sts.pos_ok     = pos_ok_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.clr_last   = (clr_addr_reg == KEY_W'(CELLS - 1));
    assign sts.i_last     = ((i_reg + CW'(1)) == count_reg);
    assign sts.j_done     = (j_reg == count_reg);
    assign sts.fill_done  = (i_reg == count_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign status      = status_reg;
    assign first_index = first_reg;
    assign last_index  = last_reg;
    assign read_id     = rid_reg;
    assign read_cell   = rcell_reg;
    assign entry_count = rcount_reg;

    `AST_IMPL(a_count_max, clk, rst_n, 1'b1, int'(count_reg) <= MAX_ENTRIES, "entry count above capacity")
    `AST_IMPL(a_append_ok, clk, rst_n, cmd.append_wr, grid_ok_reg && !full_reg, "append into full store or off grid")
    `AST_IMPL(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || m_tready, "result overwritten before transfer")

endmodule
